// ----- hw/rtl/gsf_pkg.sv -----
// GIF structure filter package: parse phases, status codes, block codes,
// result word types and the signature lookup.
// No dependencies.
package gsf_pkg;

   // Defaults and sizes
   localparam int MAX_TABLE_ENTRIES_DEF = 256;
   localparam int OUT_DEPTH             = 4;
   localparam int CNT_W                 = 10;

   // Block-level codes
   localparam logic [7:0] BLK_IMAGE   = 8'h2c;
   localparam logic [7:0] BLK_EXT     = 8'h21;
   localparam logic [7:0] BLK_TRAILER = 8'h3b;
   localparam logic [7:0] LBL_COMMENT = 8'hfe;
   localparam int         TBL_FLAG    = 7;

   typedef enum logic [3:0] {
      PH_SIG,
      PH_LSD,
      PH_GTAB,
      PH_BLOCK,
      PH_IMGDESC,
      PH_LTAB,
      PH_CODESIZE,
      PH_CHLEN,
      PH_CHDATA,
      PH_EXTLABEL,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ST_PARSING,
      ST_TRAILER,
      ST_NOTGIF,
      ST_UNKNOWN,
      ST_EARLY
   } status_type;

   // One output word
   typedef struct packed {
      logic [7:0] out_byte;
      logic       keep;
      status_type status;
      logic       last;
   } result_type;

   // Words produced by one input byte (count 0..2)
   typedef struct packed {
      logic [1:0] n;
      result_type r0;
      result_type r1;
   } parse_out_type;

   // Expected signature characters "GIF"
   function automatic logic [7:0] sig_char(input logic [1:0] idx);
      logic [7:0] c;
      unique case (idx)
         2'd0:    c = 8'h47;
         2'd1:    c = 8'h49;
         2'd2:    c = 8'h46;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ----- hw/rtl/gsf_parser.sv -----
// GIF structure parser: phase state machine, counters and per-byte result words.
// Depends on gsf_pkg.
module gsf_parser #(
   parameter int MaxTableEntries = gsf_pkg::MAX_TABLE_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,
   input  logic                  acc,
   input  logic [7:0]            in_byte,
   input  logic                  eof,
   output gsf_pkg::parse_out_type po
);
   import gsf_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [7:0]         sub_ff, sub_in;
   logic               cmt_ff, cmt_in;
   status_type         fstat_ff, fstat_in;
   logic               strip_ff;

   logic               stop_base;
   status_type         st_base;
   logic               dec_stop;
   status_type         dec_status;
   logic               dec_keep;
   logic               done;
   logic               label_keep;
   logic [CNT_W-1:0]   cnt_dec;
   logic [CNT_W-1:0]   cnt_inc;
   logic [7:0]         sub_dec;

   // Color table size in bytes: 3 * min(2 << size, MaxTableEntries)
   function automatic logic [CNT_W-1:0] table_bytes(input logic [7:0] packed_b);
      logic [CNT_W-1:0] e;
      e = CNT_W'(2) << packed_b[2:0];
      if (e > CNT_W'(MaxTableEntries)) begin
         e = CNT_W'(MaxTableEntries);
      end
      return CNT_W'(e + (e << 1));
   endfunction

   assign done       = (phase_ff == PH_DONE);
   assign label_keep = !((in_byte == LBL_COMMENT) && strip_ff);
   assign cnt_dec    = (cnt_ff != '0) ? CNT_W'(cnt_ff - 1'b1) : '0;
   assign cnt_inc    = CNT_W'(cnt_ff + 1'b1);
   assign sub_dec    = (sub_ff != '0) ? 8'(sub_ff - 1'b1) : '0;

   // Per-byte decode: keep flag and stop condition
   always_comb begin
      stop_base = 1'b0;
      st_base   = ST_PARSING;
      dec_keep  = 1'b1;
      unique case (phase_ff) inside
         PH_SIG: begin
            if ((cnt_ff < CNT_W'(3)) && (in_byte != sig_char(cnt_ff[1:0]))) begin
               stop_base = 1'b1;
               st_base   = ST_NOTGIF;
               dec_keep  = 1'b0;
            end
         end
         PH_BLOCK: begin
            if (in_byte == BLK_TRAILER) begin
               stop_base = 1'b1;
               st_base   = ST_TRAILER;
            end else if ((in_byte != BLK_IMAGE) && (in_byte != BLK_EXT)) begin
               stop_base = 1'b1;
               st_base   = ST_UNKNOWN;
               dec_keep  = 1'b0;
            end
         end
         PH_CHLEN, PH_CHDATA: begin
            dec_keep = !cmt_ff;
         end
         PH_EXTLABEL: begin
            dec_keep = label_keep;
         end
         default: begin
            dec_keep = 1'b1;
         end
      endcase
      dec_stop   = stop_base || eof;
      dec_status = stop_base ? st_base : (eof ? ST_EARLY : ST_PARSING);
   end

   // Next state
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      sub_in   = sub_ff;
      cmt_in   = cmt_ff;
      fstat_in = fstat_ff;
      if (acc && !done) begin
         unique case (phase_ff) inside
            PH_SIG: begin
               if (cnt_ff >= CNT_W'(5)) begin
                  phase_in = PH_LSD;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            PH_LSD: begin
               if (cnt_ff == CNT_W'(4)) begin
                  sub_in = in_byte;
               end
               if (cnt_ff >= CNT_W'(6)) begin
                  if (sub_ff[TBL_FLAG]) begin
                     cnt_in   = table_bytes(sub_ff);
                     phase_in = PH_GTAB;
                  end else begin
                     cnt_in   = '0;
                     phase_in = PH_BLOCK;
                  end
                  sub_in = '0;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            PH_GTAB, PH_LTAB: begin
               cnt_in = cnt_dec;
               if (cnt_dec == '0) begin
                  phase_in = (phase_ff == PH_GTAB) ? PH_BLOCK : PH_CODESIZE;
               end
            end
            PH_BLOCK: begin
               if (in_byte == BLK_IMAGE) begin
                  phase_in = PH_IMGDESC;
                  cnt_in   = '0;
               end else if (in_byte == BLK_EXT) begin
                  phase_in = PH_EXTLABEL;
               end
            end
            PH_IMGDESC: begin
               cnt_in = cnt_inc;
               if (cnt_inc >= CNT_W'(9)) begin
                  if (in_byte[TBL_FLAG]) begin
                     cnt_in   = table_bytes(in_byte);
                     phase_in = PH_LTAB;
                  end else begin
                     cnt_in   = '0;
                     phase_in = PH_CODESIZE;
                  end
               end
            end
            PH_CODESIZE: begin
               phase_in = PH_CHLEN;
            end
            PH_CHLEN: begin
               if (in_byte == 8'h00) begin
                  cmt_in   = 1'b0;
                  phase_in = PH_BLOCK;
               end else begin
                  sub_in   = in_byte;
                  phase_in = PH_CHDATA;
               end
            end
            PH_CHDATA: begin
               sub_in = sub_dec;
               if (sub_dec == '0) begin
                  phase_in = PH_CHLEN;
               end
            end
            PH_EXTLABEL: begin
               cmt_in   = !label_keep;
               phase_in = PH_CHLEN;
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
         if (dec_stop) begin
            phase_in = PH_DONE;
            fstat_in = dec_status;
            cmt_in   = 1'b0;
         end
      end
   end

   // Result words for the current byte
   always_comb begin
      po.n  = 2'd1;
      po.r0 = '{out_byte: in_byte, keep: dec_keep, status: dec_status, last: 1'b1};
      po.r1 = po.r0;
      if (done) begin
         po.r0 = '{out_byte: in_byte, keep: 1'b0, status: fstat_ff, last: 1'b1};
         po.r1 = po.r0;
      end else if ((phase_ff == PH_BLOCK) && (in_byte == BLK_EXT)) begin
         // introducer held until its label; flushed alone at end of file
         po.n  = eof ? 2'd1 : 2'd0;
         po.r0 = '{out_byte: BLK_EXT, keep: 1'b1, status: dec_status, last: 1'b1};
         po.r1 = po.r0;
      end else if (phase_ff == PH_EXTLABEL) begin
         po.n  = 2'd2;
         po.r0 = '{out_byte: BLK_EXT, keep: dec_keep, status: dec_status, last: 1'b0};
         po.r1 = '{out_byte: in_byte, keep: dec_keep, status: dec_status, last: 1'b1};
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIG;
         cnt_ff   <= '0;
         sub_ff   <= '0;
         cmt_ff   <= 1'b0;
         fstat_ff <= ST_PARSING;
         strip_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         sub_ff   <= sub_in;
         cmt_ff   <= cmt_in;
         fstat_ff <= fstat_in;
         if (csr_wr_en) begin
            strip_ff <= csr_wr_data;
         end
      end
   end

endmodule

// ----- hw/rtl/gsf_out_fifo.sv -----
// Result queue: takes zero, one or two words per cycle, hands out one while rd_en is high.
// Depends on gsf_pkg.
module gsf_out_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  gsf_pkg::parse_out_type wr_data,
   output logic                   almost_full,
   output logic                   rd_valid,
   input  logic                   rd_en,
   output gsf_pkg::result_type    rd_data
);
   import gsf_pkg::*;

   localparam int PTR_W = $clog2(OUT_DEPTH);
   localparam int CNT_QW = $clog2(OUT_DEPTH + 1);

   result_type          mem [OUT_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]   count_ff, count_in;
   logic [1:0]          wr_n;
   logic                rd_do;

   assign wr_n        = wr_en ? wr_data.n : 2'd0;
   assign rd_do       = rd_en && rd_valid;
   assign rd_valid    = (count_ff != '0);
   assign almost_full = (count_ff > CNT_QW'(OUT_DEPTH - 2));
   assign rd_data     = mem[rd_ptr_ff];

   // Pointer and fill update
   always_comb begin
      wr_ptr_in = PTR_W'(wr_ptr_ff + PTR_W'(wr_n));
      rd_ptr_in = PTR_W'(rd_ptr_ff + PTR_W'(rd_do));
      count_in  = CNT_QW'(count_ff + CNT_QW'(wr_n) - CNT_QW'(rd_do));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Word storage
   always_ff @(posedge clock) begin
      if (wr_n != 2'd0) begin
         mem[wr_ptr_ff] <= wr_data.r0;
      end
      if (wr_n == 2'd2) begin
         mem[PTR_W'(wr_ptr_ff + 1'b1)] <= wr_data.r1;
      end
   end

endmodule

// ----- hw/rtl/gif_structure_filter.sv -----
// GIF structure filter top level: one input byte per cycle when not stalled.
// Throughput: one byte per cycle when not stalled. Result words of accepted
// bytes go to a 4-word result queue (req_stall when 3+ are held) and drain
// one per cycle while rsp_stall is low; an extension label gives two words.
// Reset (synchronous) returns to the signature phase, empties the queue and
// clears strip_comments.
module gif_structure_filter #(
   parameter int MAX_TABLE_ENTRIES = gsf_pkg::MAX_TABLE_ENTRIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_file,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_keep,
   output logic [2:0] rsp_status,
   output logic       rsp_last_of_item
);
   import gsf_pkg::*;

   logic          acc;
   parse_out_type po;
   result_type    rd_word;

   assign acc = req_valid && !req_stall;

   // Parser
   gsf_parser #(
      .MaxTableEntries(MAX_TABLE_ENTRIES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .acc        (acc),
      .in_byte    (req_in_byte),
      .eof        (req_end_of_file),
      .po         (po)
   );

   // Result queue
   gsf_out_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (acc),
      .wr_data    (po),
      .almost_full(req_stall),
      .rd_valid   (rsp_valid),
      .rd_en      (!rsp_stall),
      .rd_data    (rd_word)
   );

   assign rsp_out_byte     = rd_word.out_byte;
   assign rsp_keep         = rd_word.keep;
   assign rsp_status       = rd_word.status;
   assign rsp_last_of_item = rd_word.last;

`ifndef SYNTHESIS
   a_stall_needs_words: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty result queue");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   a_word_follows: assert property (@(posedge clock) disable iff (reset)
      (acc && (po.n != 2'd0)) |=> rsp_valid)
      else $error("accepted byte produced no visible word");

   a_count_legal: assert property (@(posedge clock) disable iff (reset)
      acc |-> (po.n != 2'd3))
      else $error("parser produced more than two words");
`endif

endmodule
